FILE: rtl/split_band_deesser_assert.svh
// ---------------------------------------------------------------------------
// Split-band de-esser assertion macros
// Concurrent checks on the block clock, held off while reset is high.
// Define ASSERT_OFF to compile every check away.
// ---------------------------------------------------------------------------
`ifndef SPLIT_BAND_DEESSER_ASSERT_SVH
`define SPLIT_BAND_DEESSER_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define SBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SBD_ASSERT_IMP(lbl, ante, cons, msg)
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/sbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Split-band de-esser package
// Fixed widths, formats, register and status codes, and the bank command.
// ---------------------------------------------------------------------------
package sbd_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_W             = 18;
  localparam int SAMPLE_FRACTION_BITS = 16;
  localparam int COEF_BITS            = 16;

  // Configuration register widths.
  localparam int ALPHA_W      = 16;
  localparam int THRESH_W     = 17;
  localparam int GAIN_W       = 17;
  localparam int CHAN_COUNT_W = 4;
  localparam int CFG_DATA_W   = 17;
  localparam int CFG_INDEX_W  = 2;

  // Result fields and stream widths.
  localparam int TOTAL_W      = 16;
  localparam int IN_TDATA_W   = 24;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_TDATA_W  = 40;
  localparam int OUT_TUSER_W  = 3;

  // Datapath widths: working values, serial multiplier operands, product.
  localparam int WORK_W   = 22;
  localparam int MCAND_W  = 20;
  localparam int MPLIER_W = 17;
  localparam int PROD_W   = MCAND_W + 1 + MPLIER_W;
  localparam int CMP_W    = WORK_W + COEF_BITS + SAMPLE_FRACTION_BITS;

  // Channel index field in the bank command, wide enough for 64 channels.
  localparam int CHAN_FIELD_W = 6;

  localparam logic signed [WORK_W-1:0] ONE_VAL = WORK_W'(64'd1 << SAMPLE_FRACTION_BITS);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Register reset values.
  localparam logic [ALPHA_W-1:0]      ALPHA_RESET  = 16'd32768;
  localparam logic [THRESH_W-1:0]     THRESH_RESET = 17'd32768;
  localparam logic [GAIN_W-1:0]       GAIN_RESET   = 17'd65536;
  localparam logic [CHAN_COUNT_W-1:0] CHAN_RESET   = 4'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ALPHA     = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_GAIN      = 2'd2,
    REG_CHANNELS  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_IN_RANGE  = 2'd1,
    ST_OUT_RANGE = 2'd2,
    ST_MISALIGN  = 2'd3
  } frame_status_t;

  // Commands from the sequencer to the low-band bank store.
  typedef struct packed {
    logic                    frame_start;
    logic                    frame_zero;
    logic                    rd_en;
    logic                    wr_en;
    logic [CHAN_FIELD_W-1:0] chan;
    logic [SAMPLE_W-1:0]     wr_data;
    logic                    frame_end;
    logic                    commit;
  } bank_cmd_t;

endpackage

FILE: rtl/sbd_serial_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Split-band de-esser serial multiplier
// Signed by unsigned shift-and-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module sbd_serial_mul (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [sbd_pkg::MCAND_W-1:0]      a,
  input  logic        [sbd_pkg::MPLIER_W-1:0]     b,
  output logic signed [sbd_pkg::PROD_W-1:0]       product,
  output logic                                    done
);
  import sbd_pkg::*;

  localparam int CNT_W = $clog2(MPLIER_W + 1);

  logic signed [MCAND_W:0]   hi;
  logic        [MPLIER_W-1:0] lo;
  logic signed [MCAND_W-1:0] a_q;
  logic signed [MCAND_W:0]   addend;
  logic signed [MCAND_W:0]   sum;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;

  // Add the multiplicand when the current multiplier bit is set.
  assign addend = lo[0] ? {a_q[MCAND_W-1], a_q} : '0;
  assign sum    = hi + addend;

  // The product builds up in the upper half; settled bits shift into lo.
  assign product = $signed({hi, lo});

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MPLIER_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial product shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= '0;
      lo  <= b;
      a_q <= a;
    end else if (busy) begin
      hi <= sum >>> 1;
      lo <= {sum[0], lo[MPLIER_W-1:1]};
    end
  end

endmodule

FILE: rtl/sbd_bank_store.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Split-band de-esser low-band bank store
// Two banks of per-channel lowpass state with commit and rollback.
// ---------------------------------------------------------------------------
module sbd_bank_store #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sbd_pkg::bank_cmd_t             cmd,
  output logic [sbd_pkg::SAMPLE_W-1:0]   rd_data
);
  import sbd_pkg::*;

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ADDR_W = CH_W + 1;
  localparam int DEPTH  = 2 ** ADDR_W;

  logic [SAMPLE_W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0]        valid;
  logic [MAX_CHANNELS-1:0] sel;
  logic [MAX_CHANNELS-1:0] touched;
  logic                    zero_state;
  logic [CH_W-1:0]         ch;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic [SAMPLE_W-1:0]     rd_q;
  logic                    rd_blank;

  assign ch = cmd.chan[CH_W-1:0];

  // A channel touched this frame reads its working bank, else its committed bank.
  assign rd_addr = {touched[ch] ? ~sel[ch] : sel[ch], ch};
  assign wr_addr = {~sel[ch], ch};

  // An entry never written, or an untouched channel in a zeroing frame, reads zero.
  assign rd_data = rd_blank ? '0 : rd_q;

  // Bank memory with a registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_blank <= !valid[rd_addr] || (!touched[ch] && zero_state);
    end
  end

  // Entry valid bits, bank selects and per-frame tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      sel        <= '0;
      touched    <= '0;
      zero_state <= 1'b0;
    end else begin
      if (cmd.frame_start) begin
        touched    <= '0;
        zero_state <= cmd.frame_zero;
      end
      if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
        touched[ch]    <= 1'b1;
      end
      if (cmd.frame_end) begin
        // A clean frame flips touched channels and zeroes the rest if asked.
        if (cmd.commit) begin
          for (int c = 0; c < MAX_CHANNELS; c++) begin
            if (touched[c]) begin
              sel[c] <= ~sel[c];
            end else if (zero_state) begin
              valid[{sel[c], CH_W'(c)}] <= 1'b0;
            end
          end
        end
        touched    <= '0;
        zero_state <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/split_band_deesser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Split-band de-esser
// Per-channel one-pole crossover with high-band attenuation and frame commit.
// ---------------------------------------------------------------------------
// Channel   Direction  Carries
// cfg       in         register writes: alpha, threshold, gain, channel count
// s_axis    in         one input sample item with frame reset and last marks
// m_axis    out        one result item per input item, status on frame end
//
// An item steps through start, read, difference, first product, high band,
// a second product only when attenuated, sum and finish; a faulted item
// goes from start straight to finish. The shared serial multiplier works
// through one bit of its 17-bit coefficient per cycle, used once or twice.
// Reset is synchronous; no clearing pass is needed, as bank entries carry
// valid bits. A stalled output holds the result; the next item is accepted
// meanwhile and waits in its last step until the output register frees.
// ---------------------------------------------------------------------------
`include "split_band_deesser_assert.svh"

module split_band_deesser #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sbd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [sbd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [17:0] sample
  input  logic [sbd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // [0] frame_reset
  input  logic [sbd_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [17:0] out_sample, [33:18] attenuated_total
  output logic [sbd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // [0] was_attenuated, [2:1] frame_status
  output logic [sbd_pkg::OUT_TUSER_W-1:0]      m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import sbd_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [6:0] MAX_N = 7'(MAX_CHANNELS);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_START  = 9'b000000010,
    S_READ   = 9'b000000100,
    S_DIFF   = 9'b000001000,
    S_MUL1   = 9'b000010000,
    S_HIGH   = 9'b000100000,
    S_MUL2   = 9'b001000000,
    S_SUM    = 9'b010000000,
    S_FINISH = 9'b100000000
  } state_t;

  // Configuration registers.
  logic [ALPHA_W-1:0]      alpha;
  logic [THRESH_W-1:0]     thresh;
  logic [GAIN_W-1:0]       gain;
  logic [CHAN_COUNT_W-1:0] chan_count;

  // Control state.
  state_t          state, state_next;
  logic            pending, pending_next;
  frame_status_t   fault, fault_next;
  logic [CH_W-1:0] pos, pos_next;
  logic [TOTAL_W-1:0] att_count, att_count_next;
  logic            out_valid, out_valid_next;

  // Item payload and working values.
  logic signed [SAMPLE_W-1:0] x_q;
  logic                       rst_q;
  logic                       last_q;
  logic [CH_W-1:0]            chan;
  logic signed [WORK_W-1:0]   s_q;
  logic signed [WORK_W-1:0]   low_q;
  logic signed [WORK_W-1:0]   ph_q;
  logic signed [WORK_W-1:0]   y_q;
  logic                       hit_q;
  logic                       att_q;

  // Output register.
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_att;
  logic                out_last;
  frame_status_t       out_status;
  logic [TOTAL_W-1:0]  out_total;

  // Datapath signals.
  logic [6:0]               cc_ext;
  logic [6:0]               n_act;
  logic [CH_W-1:0]          pos_eff;
  logic [CH_W-1:0]          chan_sel;
  frame_status_t            fault_eff;
  logic signed [WORK_W-1:0] x_ext;
  logic signed [WORK_W-1:0] s_ext;
  logic signed [WORK_W-1:0] diff;
  logic signed [WORK_W-1:0] rounded;
  logic signed [WORK_W-1:0] high;
  logic [WORK_W-1:0]        mag;
  logic [CMP_W-1:0]         mag_cmp;
  logic [CMP_W-1:0]         thr_cmp;
  logic                     hit;
  logic signed [WORK_W-1:0] y;
  logic                     y_bad;
  logic                     x_bad;
  logic                     out_load;
  frame_status_t            end_status;

  logic [SAMPLE_W-1:0]        rd_data;
  bank_cmd_t                  cmd;
  logic                       mul_start;
  logic signed [MCAND_W-1:0]  mul_a;
  logic [MPLIER_W-1:0]        mul_b;
  logic signed [PROD_W-1:0]   mul_prod;
  logic                       mul_done;

  sbd_bank_store #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  sbd_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .product (mul_prod),
    .done    (mul_done)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha      <= ALPHA_RESET;
      thresh     <= THRESH_RESET;
      gain       <= GAIN_RESET;
      chan_count <= CHAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHA:     alpha      <= cfg_data[ALPHA_W-1:0];
        REG_THRESHOLD: thresh     <= cfg_data[THRESH_W-1:0];
        REG_GAIN:      gain       <= cfg_data[GAIN_W-1:0];
        REG_CHANNELS:  chan_count <= cfg_data[CHAN_COUNT_W-1:0];
      endcase
    end
  end

  // Active channel count, clamped to one and to the bank size.
  assign cc_ext = 7'(chan_count);
  assign n_act  = (chan_count == '0) ? 7'd1 : ((cc_ext > MAX_N) ? MAX_N : cc_ext);

  // Channel of the item: a fresh frame starts at zero, a stale position wraps.
  assign pos_eff   = pending ? '0 : pos;
  assign chan_sel  = (7'(pos_eff) >= n_act) ? '0 : pos_eff;
  assign fault_eff = pending ? ST_OK : fault;

  // Lowpass, split and attenuation arithmetic, one step per state.
  assign x_ext   = WORK_W'(x_q);
  assign s_ext   = WORK_W'($signed(rd_data));
  assign diff    = x_ext - s_ext;
  assign rounded = WORK_W'($signed(mul_prod[PROD_W-1:COEF_BITS]))
                 + WORK_W'({1'b0, mul_prod[COEF_BITS-1]});
  assign high    = x_ext - low_q;
  assign mag     = high[WORK_W-1] ? WORK_W'(-high) : WORK_W'(high);
  assign mag_cmp = CMP_W'(mag) << COEF_BITS;
  assign thr_cmp = CMP_W'(thresh) << SAMPLE_FRACTION_BITS;
  assign hit     = mag_cmp >= thr_cmp;
  assign y       = low_q + ph_q;
  assign y_bad   = (y < -ONE_VAL) || (y > ONE_VAL);
  assign x_bad   = (x_ext < -ONE_VAL) || (x_ext > ONE_VAL);

  // The result may go out once the output register is free.
  assign out_load   = (state == S_FINISH) && (!out_valid || m_axis_tready);
  assign end_status = (7'(chan) != (n_act - 7'd1)) ? ST_MISALIGN : fault;

  // Sequencer next state and commands.
  always_comb begin
    state_next     = state;
    pending_next   = pending;
    fault_next     = fault;
    pos_next       = pos;
    att_count_next = att_count;
    cmd            = '0;
    cmd.chan       = CHAN_FIELD_W'(chan);
    cmd.wr_data    = low_q[SAMPLE_W-1:0];
    mul_start      = 1'b0;
    mul_a          = diff[MCAND_W-1:0];
    mul_b          = MPLIER_W'(alpha);
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if (pending) begin
          pending_next    = 1'b0;
          att_count_next  = '0;
          cmd.frame_start = 1'b1;
          cmd.frame_zero  = rst_q;
        end
        fault_next = fault_eff;
        if (fault_eff != ST_OK) begin
          state_next = S_FINISH;
        end else if (x_bad) begin
          fault_next = ST_IN_RANGE;
          state_next = S_FINISH;
        end else begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        mul_start  = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        if (mul_done) begin
          state_next = S_HIGH;
        end
      end
      S_HIGH: begin
        mul_a = high[MCAND_W-1:0];
        mul_b = MPLIER_W'(gain);
        if (hit) begin
          mul_start  = 1'b1;
          state_next = S_MUL2;
        end else begin
          state_next = S_SUM;
        end
      end
      S_MUL2: begin
        if (mul_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (y_bad) begin
          fault_next = ST_OUT_RANGE;
        end else begin
          cmd.wr_en = 1'b1;
          if (hit_q && (att_count != TOTAL_MAX)) begin
            att_count_next = att_count + TOTAL_W'(1);
          end
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
          if (last_q) begin
            cmd.frame_end  = 1'b1;
            cmd.commit     = (end_status == ST_OK);
            fault_next     = ST_OK;
            att_count_next = '0;
            pos_next       = '0;
            pending_next   = 1'b1;
          end else begin
            pos_next = ((7'(chan) + 7'd1) >= n_act) ? '0 : CH_W'(chan + CH_W'(1));
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads and downstream acceptance.
  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= 1'b1;
      fault     <= ST_OK;
      pos       <= '0;
      att_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pending   <= pending_next;
      fault     <= fault_next;
      pos       <= pos_next;
      att_count <= att_count_next;
      out_valid <= out_valid_next;
    end
  end

  // Item payload and intermediate results.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      x_q    <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
      rst_q  <= s_axis_tuser[0];
      last_q <= s_axis_tlast;
    end
    if (state == S_START) begin
      chan  <= chan_sel;
      y_q   <= '0;
      att_q <= 1'b0;
    end
    if (state == S_DIFF) begin
      s_q <= s_ext;
    end
    if (state == S_MUL1 && mul_done) begin
      low_q <= s_q + rounded;
    end
    if (state == S_HIGH) begin
      hit_q <= hit;
      ph_q  <= high;
    end
    if (state == S_MUL2 && mul_done) begin
      ph_q <= rounded;
    end
    if (state == S_SUM && !y_bad) begin
      y_q   <= y;
      att_q <= hit_q;
    end
  end

  // Output register load; status and count only on a frame's last item.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= y_q[SAMPLE_W-1:0];
      out_att    <= att_q;
      out_last   <= last_q;
      if (last_q) begin
        out_status <= end_status;
        out_total  <= (end_status == ST_OK) ? att_count : '0;
      end else begin
        out_status <= ST_OK;
        out_total  <= '0;
      end
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - TOTAL_W - SAMPLE_W){1'b0}}, out_total, out_sample};
  assign m_axis_tuser  = {out_status, out_att};
  assign m_axis_tlast  = out_last;

  // Mid-frame results carry no status and no count.
  `SBD_ASSERT_IMP(a_mid_frame_clean, m_axis_tvalid && !out_last, (out_status == ST_OK) && (out_total == '0), "mid-frame item has status or count")
  // A faulted or misaligned frame reports no count.
  `SBD_ASSERT_IMP(a_fault_no_total, m_axis_tvalid && (out_status != ST_OK), out_total == '0, "faulted frame reports a count")
  // Once an item is taken the block works on it before taking another.
  `SBD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule
